### sv/cmdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdp_pkg
// Shared types, constants and helpers of the command string parser.
// ----------------------------------------------------------------------------
package cmdp_pkg;

    // value store capacity; at most VALUE_CAP-1 value bytes are kept
    localparam int VALUE_CAP = 32;
    localparam int CNT_W     = $clog2(VALUE_CAP);

    localparam int NUM_W     = 17;
    localparam int LEN_W     = 5;
    localparam int STAT_W    = 4;

    localparam logic [NUM_W-1:0] NUM_MAX    = NUM_W'(99999);
    localparam logic [2:0]       MAX_DIGITS = 3'd6;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
    localparam logic [7:0] CH_QUERY  = 8'h3F;  // '?'
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

    // verdict status codes
    localparam logic [STAT_W-1:0] ST_EMPTY       = 4'd0;
    localparam logic [STAT_W-1:0] ST_QUERY_NOVAL = 4'd1;
    localparam logic [STAT_W-1:0] ST_ACTION      = 4'd2;
    localparam logic [STAT_W-1:0] ST_BAD_CMD     = 4'd3;
    localparam logic [STAT_W-1:0] ST_BAD_SYMBOL  = 4'd4;
    localparam logic [STAT_W-1:0] ST_BAD_ACTION  = 4'd5;
    localparam logic [STAT_W-1:0] ST_BAD_NUMBER  = 4'd6;
    localparam logic [STAT_W-1:0] ST_QUERY_VAL   = 4'd7;
    localparam logic [STAT_W-1:0] ST_BAD_QVAL    = 4'd8;
    localparam logic [STAT_W-1:0] ST_NO_END      = 4'd9;

    typedef enum logic [1:0] {
        PH_DIGITS = 2'd0,
        PH_VALUE  = 2'd1,
        PH_SKIP   = 2'd2
    } t_phase;

    typedef struct packed {
        logic              is_verdict;
        logic [STAT_W-1:0] status;
        logic [NUM_W-1:0]  cmd_number;
        logic              is_query;
        logic [LEN_W-1:0]  value_length;
        logic [7:0]        value_char;
        logic [LEN_W-1:0]  value_pos;
    } t_result;

    // fit a value counter into the 5-bit result fields
    function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[LEN_W-1:0];
    endfunction

endpackage

### sv/cmdp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdp_core
// Parse state and per-byte decode; one byte per step, at most one result.
// ----------------------------------------------------------------------------
module cmdp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output cmdp_pkg::t_result o_res
);
    import cmdp_pkg::*;

    t_phase           r_phase,    n_phase;
    logic [2:0]       r_dcount,   n_dcount;
    logic [NUM_W-1:0] r_number,   n_number;
    logic             r_query,    n_query;
    logic [CNT_W-1:0] r_vcount,   n_vcount;
    logic             r_first_dig, n_first_dig;

    logic             w_is_digit;
    logic             w_is_nul;
    logic             w_is_sym;
    logic [2:0]       w_dcount_inc;
    logic [NUM_W+3:0] w_product;
    logic             w_room;
    logic [STAT_W-1:0] w_end_status;

    assign w_is_digit   = i_byte inside {[CH_ZERO:CH_NINE]};
    assign w_is_nul     = (i_byte == CH_NUL);
    assign w_is_sym     = (i_byte == CH_HASH) || (i_byte == CH_QUERY);
    assign w_dcount_inc = r_dcount + 3'd1;
    assign w_product    = (NUM_W+4)'(r_number) * (NUM_W+4)'(10)
                        + (NUM_W+4)'(i_byte - CH_ZERO);
    assign w_room       = (r_vcount < CNT_W'(VALUE_CAP - 1));

    always_comb begin
        if (!r_query) begin
            w_end_status = (r_vcount == '0) ? ST_BAD_ACTION : ST_ACTION;
        end else if (r_vcount == '0) begin
            w_end_status = ST_QUERY_NOVAL;
        end else if (!r_first_dig || r_vcount != CNT_W'(1)) begin
            w_end_status = ST_BAD_QVAL;
        end else begin
            w_end_status = ST_QUERY_VAL;
        end
    end

    // next state
    always_comb begin
        logic new_cmd;
        new_cmd     = 1'b0;
        n_phase     = r_phase;
        n_dcount    = r_dcount;
        n_number    = r_number;
        n_query     = r_query;
        n_vcount    = r_vcount;
        n_first_dig = r_first_dig;
        case (r_phase)
            PH_DIGITS: begin
                if (w_is_digit) begin
                    n_dcount = w_dcount_inc;
                    if (w_dcount_inc >= MAX_DIGITS) begin
                        n_phase = PH_SKIP;
                    end else if (w_product > (NUM_W+4)'(NUM_MAX)) begin
                        n_number = NUM_MAX;
                    end else begin
                        n_number = w_product[NUM_W-1:0];
                    end
                end else if (r_dcount == 3'd0 || !w_is_sym) begin
                    if (w_is_nul) new_cmd = 1'b1;
                    else          n_phase = PH_SKIP;
                end else begin
                    n_query     = (i_byte == CH_QUERY);
                    n_vcount    = '0;
                    n_first_dig = 1'b0;
                    n_phase     = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (w_is_nul) begin
                    new_cmd = 1'b1;
                end else if (i_byte == CH_DOLLAR) begin
                    n_phase = PH_SKIP;
                end else if (w_room) begin
                    if (r_vcount == '0) n_first_dig = w_is_digit;
                    n_vcount = r_vcount + CNT_W'(1);
                end
            end
            PH_SKIP: begin
                if (w_is_nul) new_cmd = 1'b1;
            end
            default: begin
                new_cmd = 1'b1;
            end
        endcase
        if (new_cmd) begin
            n_phase     = PH_DIGITS;
            n_dcount    = 3'd0;
            n_number    = '0;
            n_query     = 1'b0;
            n_vcount    = '0;
            n_first_dig = 1'b0;
        end
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_DIGITS: begin
                if (w_is_digit) begin
                    if (w_dcount_inc >= MAX_DIGITS) begin
                        o_res_valid      = 1'b1;
                        o_res.is_verdict = 1'b1;
                        o_res.status     = ST_BAD_NUMBER;
                    end
                end else if (r_dcount == 3'd0) begin
                    o_res_valid      = 1'b1;
                    o_res.is_verdict = 1'b1;
                    o_res.status     = w_is_nul ? ST_EMPTY : ST_BAD_CMD;
                end else if (!w_is_sym) begin
                    o_res_valid      = 1'b1;
                    o_res.is_verdict = 1'b1;
                    o_res.status     = ST_BAD_SYMBOL;
                    o_res.cmd_number = r_number;
                end
            end
            PH_VALUE: begin
                if (w_is_nul || i_byte == CH_DOLLAR) begin
                    o_res_valid        = 1'b1;
                    o_res.is_verdict   = 1'b1;
                    o_res.status       = w_is_nul ? ST_NO_END : w_end_status;
                    o_res.cmd_number   = r_number;
                    o_res.is_query     = r_query;
                    o_res.value_length = to_len(r_vcount);
                end else if (w_room) begin
                    o_res_valid      = 1'b1;
                    o_res.cmd_number = r_number;
                    o_res.is_query   = r_query;
                    o_res.value_char = i_byte;
                    o_res.value_pos  = to_len(r_vcount);
                end
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
        if (!i_step) o_res_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DIGITS;
            r_dcount    <= 3'd0;
            r_number    <= '0;
            r_query     <= 1'b0;
            r_vcount    <= '0;
            r_first_dig <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_dcount    <= n_dcount;
            r_number    <= n_number;
            r_query     <= n_query;
            r_vcount    <= n_vcount;
            r_first_dig <= n_first_dig;
        end
    end

endmodule

### sv/command_string_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_string_parser_top
// Byte-wide command text parser: echoes value bytes and gives one verdict
// per command.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_cmd_byte
//  result    out        o_valid / i_ready   o_is_verdict .. o_value_pos
//
//  one byte per cycle sustained while i_ready is high; a byte is held in
//  the input register and its result (if any) is then registered in the
//  result register; the rate is set by the parse state update in cmdp_core
//  synchronous active-low reset clears the parse state and both valids
//  a stalled result holds both stages; o_ready follows i_ready combinationally
//  while both registers are full, so no transaction is dropped while stalled
// ----------------------------------------------------------------------------
module command_string_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_cmd_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_verdict,
    output logic [cmdp_pkg::STAT_W-1:0]   o_status,
    output logic [cmdp_pkg::NUM_W-1:0]    o_cmd_number,
    output logic                          o_is_query,
    output logic [cmdp_pkg::LEN_W-1:0]    o_value_length,
    output logic [7:0]                    o_value_char,
    output logic [cmdp_pkg::LEN_W-1:0]    o_value_pos
);
    import cmdp_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    logic       w_advance;   // result slot can take a new value
    logic       w_step;      // held byte is parsed this cycle
    logic       w_res_valid;
    t_result    w_res;

    assign w_advance = !r_out_valid || i_ready;
    assign w_step    = r_in_valid && w_advance;
    assign o_ready   = !r_in_valid || w_advance;

    cmdp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // input stage: take a byte when the register is empty or the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_cmd_byte;
        end
    end

    // result stage: bytes without a result leave the slot empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_verdict   = r_out.is_verdict;
    assign o_status       = r_out.status;
    assign o_cmd_number   = r_out.cmd_number;
    assign o_is_query     = r_out.is_query;
    assign o_value_length = r_out.value_length;
    assign o_value_char   = r_out.value_char;
    assign o_value_pos    = r_out.value_pos;

endmodule

### sv/cmdp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdp_checker
// Port-level checks of the command string parser, bound to the top level.
// ----------------------------------------------------------------------------
module cmdp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_is_verdict,
    input logic [cmdp_pkg::STAT_W-1:0] o_status,
    input logic [cmdp_pkg::NUM_W-1:0]  o_cmd_number,
    input logic                        o_is_query,
    input logic [cmdp_pkg::LEN_W-1:0]  o_value_length,
    input logic [7:0]                  o_value_char,
    input logic [cmdp_pkg::LEN_W-1:0]  o_value_pos
);
    import cmdp_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_value_char) && $stable(o_is_verdict))
        else $error("result changed while stalled");

    // echo transactions carry no status or length
    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_verdict |-> o_status == ST_EMPTY && o_value_length == '0)
        else $error("echo carries verdict fields");

    // verdicts carry no echoed byte
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_verdict |-> o_value_char == 8'h00 && o_value_pos == '0)
        else $error("verdict carries echo fields");

    // early verdicts have no number and no symbol
    a_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_verdict && (o_status == ST_EMPTY || o_status == ST_BAD_CMD
            || o_status == ST_BAD_NUMBER)
        |-> o_cmd_number == '0 && !o_is_query && o_value_length == '0)
        else $error("early verdict carries parse data");

endmodule

bind command_string_parser_top cmdp_checker u_cmdp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_is_verdict   (o_is_verdict),
    .o_status       (o_status),
    .o_cmd_number   (o_cmd_number),
    .o_is_query     (o_is_query),
    .o_value_length (o_value_length),
    .o_value_char   (o_value_char),
    .o_value_pos    (o_value_pos)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command string parser. A directed set of
// commands hits each verdict and corner case, then random command streams
// (mostly well-formed, some broken, some noise) run under three idling
// profiles. A scoreboard class predicts echo and verdict results per
// accepted byte and checks each result transaction in order.
// ----------------------------------------------------------------------------
module tb_top;

    import cmdp_pkg::*;

    // ------------------------------------------------------------------
    // scoreboard: parse-state predictor plus queue of expected results
    // ------------------------------------------------------------------
    class parse_scoreboard;
        t_phase      phase;
        int unsigned digit_count;
        int unsigned number_acc;
        bit          query_flag;
        int unsigned value_count;
        bit          first_value_digit;
        t_result     expected_results[$];
        int          fail_count;

        function new();
            fail_count = 0;
            start_command();
        endfunction

        function void start_command();
            phase             = PH_DIGITS;
            digit_count       = 0;
            number_acc        = 0;
            query_flag        = 1'b0;
            value_count       = 0;
            first_value_digit = 1'b0;
        endfunction

        function bit is_dec(logic [7:0] c);
            return (c >= CH_ZERO) && (c <= CH_NINE);
        endfunction

        function t_result verdict(logic [STAT_W-1:0] st, int unsigned num, bit q,
                                  int unsigned len);
            t_result r;
            r              = '0;
            r.is_verdict   = 1'b1;
            r.status       = st;
            r.cmd_number   = NUM_W'(num);
            r.is_query     = q;
            r.value_length = LEN_W'(len);
            return r;
        endfunction

        // advance the parse state by one accepted byte
        function void note_byte(logic [7:0] c);
            t_result           r;
            logic [STAT_W-1:0] st;
            int unsigned       d;
            case (phase)
                PH_DIGITS: begin
                    if (is_dec(c)) begin
                        d = 32'(c - CH_ZERO);
                        digit_count++;
                        if (digit_count >= MAX_DIGITS) begin
                            expected_results.push_back(verdict(ST_BAD_NUMBER, 0, 1'b0, 0));
                            phase = PH_SKIP;
                        end else if (number_acc > (int'(NUM_MAX) - d) / 10) begin
                            number_acc = 32'(NUM_MAX);
                        end else begin
                            number_acc = number_acc * 10 + d;
                        end
                    end else if (digit_count == 0) begin
                        // nothing before the first non-digit
                        if (c == CH_NUL) begin
                            expected_results.push_back(verdict(ST_EMPTY, 0, 1'b0, 0));
                            start_command();
                        end else begin
                            expected_results.push_back(verdict(ST_BAD_CMD, 0, 1'b0, 0));
                            phase = PH_SKIP;
                        end
                    end else if (c == CH_HASH || c == CH_QUERY) begin
                        query_flag        = (c == CH_QUERY);
                        value_count       = 0;
                        first_value_digit = 1'b0;
                        phase             = PH_VALUE;
                    end else begin
                        expected_results.push_back(verdict(ST_BAD_SYMBOL, number_acc, 1'b0, 0));
                        if (c == CH_NUL) begin
                            start_command();
                        end else begin
                            phase = PH_SKIP;
                        end
                    end
                end
                PH_VALUE: begin
                    if (c == CH_NUL) begin
                        expected_results.push_back(verdict(ST_NO_END, number_acc, query_flag,
                                                           value_count));
                        start_command();
                    end else if (c == CH_DOLLAR) begin
                        if (!query_flag) begin
                            st = (value_count == 0) ? ST_BAD_ACTION : ST_ACTION;
                        end else if (value_count == 0) begin
                            st = ST_QUERY_NOVAL;
                        end else if (!first_value_digit || value_count != 1) begin
                            st = ST_BAD_QVAL;
                        end else begin
                            st = ST_QUERY_VAL;
                        end
                        expected_results.push_back(verdict(st, number_acc, query_flag,
                                                           value_count));
                        phase = PH_SKIP;
                    end else if (value_count < VALUE_CAP - 1) begin
                        if (value_count == 0) begin
                            first_value_digit = is_dec(c);
                        end
                        r            = '0;
                        r.cmd_number = NUM_W'(number_acc);
                        r.is_query   = query_flag;
                        r.value_char = c;
                        r.value_pos  = LEN_W'(value_count);
                        expected_results.push_back(r);
                        value_count++;
                    end
                    // bytes past the value cap are dropped silently
                end
                default: begin
                    // skipping until the terminator
                    if (c == CH_NUL) begin
                        start_command();
                    end
                end
            endcase
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(t_result act);
            t_result ex;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display({"unexpected result: verdict=%0d status=%0d num=%0d q=%0d",
                              " len=%0d ch=%02h pos=%0d"},
                             act.is_verdict, act.status, act.cmd_number, act.is_query,
                             act.value_length, act.value_char, act.value_pos);
                end
                return;
            end
            ex = expected_results.pop_front();
            if (act.is_verdict !== ex.is_verdict || act.status !== ex.status ||
                act.cmd_number !== ex.cmd_number || act.is_query !== ex.is_query ||
                act.value_length !== ex.value_length || act.value_char !== ex.value_char ||
                act.value_pos !== ex.value_pos) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display({"mismatch: expected verdict=%0d status=%0d num=%0d q=%0d",
                              " len=%0d ch=%02h pos=%0d"},
                             ex.is_verdict, ex.status, ex.cmd_number, ex.is_query,
                             ex.value_length, ex.value_char, ex.value_pos);
                    $display({"          actual   verdict=%0d status=%0d num=%0d q=%0d",
                              " len=%0d ch=%02h pos=%0d"},
                             act.is_verdict, act.status, act.cmd_number, act.is_query,
                             act.value_length, act.value_char, act.value_pos);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [7:0]          i_cmd_byte;
    logic                o_valid;
    logic                i_ready;
    logic                o_is_verdict;
    logic [STAT_W-1:0]   o_status;
    logic [NUM_W-1:0]    o_cmd_number;
    logic                o_is_query;
    logic [LEN_W-1:0]    o_value_length;
    logic [7:0]          o_value_char;
    logic [LEN_W-1:0]    o_value_pos;

    parse_scoreboard sb;

    // idle percentages of sender and receiver, changed per phase
    int          send_idle;
    int          recv_idle;
    // bytes accepted so far, drives the length of each random phase
    int          sent_count;
    // command bytes waiting to be driven
    logic [7:0]  tx_bytes[$];

    command_string_parser_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd_byte     (i_cmd_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_is_verdict   (o_is_verdict),
        .o_status       (o_status),
        .o_cmd_number   (o_cmd_number),
        .o_is_query     (o_is_query),
        .o_value_length (o_value_length),
        .o_value_char   (o_value_char),
        .o_value_pos    (o_value_pos)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard limit on run time, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor: check the result transaction first, then note the input
    // transaction; the result path is registered so neither depends on the other
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_result({o_is_verdict, o_status, o_cmd_number, o_is_query,
                                 o_value_length, o_value_char, o_value_pos});
            end
            if (i_valid && o_ready) begin
                sb.note_byte(i_cmd_byte);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // any value byte that neither ends the value nor the command
    function automatic logic [7:0] rand_value_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255, 1));
        end while (b == CH_DOLLAR);
        return b;
    endfunction

    // queue a text fragment, optionally closed by the terminator
    task automatic add_text(input string s, input bit with_nul);
        for (int i = 0; i < s.len(); i++) begin
            tx_bytes.push_back(s[i]);
        end
        if (with_nul) begin
            tx_bytes.push_back(CH_NUL);
        end
    endtask

    // drive every queued byte, with random sender gaps between transactions
    task automatic send_pending();
        while (tx_bytes.size() != 0) begin
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_valid    <= 1'b1;
            i_cmd_byte <= tx_bytes.pop_front();
            do begin
                @(posedge i_clk);
            end while (!o_ready);
            sent_count++;
        end
    endtask

    // random command streams for about n_bytes accepted bytes
    task automatic run_random(input int n_bytes);
        int         first;
        int         kind;
        int         ndig;
        int         vlen;
        int         k;
        int         idx;
        bit         q;
        logic [7:0] b;
        first = sent_count;
        while (sent_count - first < n_bytes) begin
            kind = $urandom_range(99);
            if (kind < 72) begin
                // well-formed shape with random content
                ndig = ($urandom_range(9) == 0) ? $urandom_range(7, 6)
                                                : $urandom_range(5, 1);
                repeat (ndig) tx_bytes.push_back(rand_digit());
                if (ndig < 6) begin
                    q = 1'($urandom_range(1));
                    tx_bytes.push_back(q ? CH_QUERY : CH_HASH);
                    k = $urandom_range(99);
                    if (k < 15) begin
                        vlen = 0;
                    end else if (k < 45) begin
                        vlen = 1;
                    end else if (k < 92) begin
                        vlen = $urandom_range(6, 2);
                    end else begin
                        // long value, crosses the store cap now and then
                        vlen = $urandom_range(36, 28);
                    end
                    for (idx = 0; idx < vlen; idx++) begin
                        if (idx == 0 && $urandom_range(1)) begin
                            tx_bytes.push_back(rand_digit());
                        end else begin
                            tx_bytes.push_back(rand_value_byte());
                        end
                    end
                    if ($urandom_range(19) == 0) begin
                        // terminator inside the value
                        tx_bytes.push_back(CH_NUL);
                    end else begin
                        tx_bytes.push_back(CH_DOLLAR);
                        repeat ($urandom_range(3)) tx_bytes.push_back(8'($urandom_range(255, 1)));
                        tx_bytes.push_back(CH_NUL);
                    end
                end else begin
                    repeat ($urandom_range(2)) tx_bytes.push_back(8'($urandom_range(255, 1)));
                    tx_bytes.push_back(CH_NUL);
                end
            end else if (kind < 88) begin
                // broken commands
                case ($urandom_range(2))
                    0: begin
                        do begin
                            b = 8'($urandom_range(255, 1));
                        end while (b >= CH_ZERO && b <= CH_NINE);
                        tx_bytes.push_back(b);
                        repeat ($urandom_range(2)) tx_bytes.push_back(8'($urandom_range(255, 1)));
                        tx_bytes.push_back(CH_NUL);
                    end
                    1: begin
                        repeat ($urandom_range(5, 1)) tx_bytes.push_back(rand_digit());
                        do begin
                            b = 8'($urandom_range(255));
                        end while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_HASH ||
                                   b == CH_QUERY);
                        tx_bytes.push_back(b);
                        tx_bytes.push_back(CH_NUL);
                    end
                    default: begin
                        tx_bytes.push_back(CH_NUL);
                    end
                endcase
            end else begin
                // raw noise, then a terminator to resync
                repeat ($urandom_range(8, 1)) tx_bytes.push_back(8'($urandom_range(255)));
                tx_bytes.push_back(CH_NUL);
            end
            send_pending();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        sb         = new();
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cmd_byte = 8'h00;
        sent_count = 0;
        send_idle  = 10;
        recv_idle  = 65;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every verdict and the corner cases
        add_text("", 1'b1);            // empty command
        add_text("A", 1'b1);           // non-digit first
        add_text("1", 1'b1);           // terminator in place of the symbol
        add_text("2x", 1'b1);          // wrong symbol, then skip
        add_text("000000", 1'b1);      // sixth digit
        add_text("99999?5$", 1'b1);    // largest number, valid query value
        add_text("3#", 1'b1);          // terminator inside the value
        add_text("1?$", 1'b1);         // query without value
        add_text("4#$", 1'b1);         // action with empty value
        add_text("6?56$", 1'b1);       // query value too long
        add_text("8#", 1'b0);          // action with extreme value bytes
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(8'h01);
        add_text("$z", 1'b1);          // junk after the decision is skipped
        add_text("1?", 1'b0);          // value past the store cap
        tx_bytes.push_back(rand_digit());
        repeat (32) tx_bytes.push_back(rand_value_byte());
        add_text("$", 1'b1);
        send_pending();

        // random phases with different idling
        run_random(140);
        send_idle = 65;
        recv_idle = 10;
        run_random(140);
        send_idle = 0;
        recv_idle = 0;
        run_random(140);

        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then keep the clock running to catch stray results
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.fail_count == 0 && sb.expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
sv/cmdp_pkg.sv
sv/cmdp_core.sv
sv/command_string_parser_top.sv
sv/cmdp_checker.sv
bench/tb_top.sv
